// ===== rtl/nux_pkg.sv =====
// package with types, constants and round functions for the nux block cipher
`timescale 1ns / 1ps

package nux_pkg;

    localparam int ROUND_COUNT = 31;
    localparam int ROUND_W     = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } t_block;

    typedef struct packed {
        logic [63:0] kh;
        logic [63:0] kl;
    } t_key;

    typedef logic [3:0] t_sbox [16];
    typedef logic [3:0] t_perm [16];

    localparam t_sbox SBOX = '{
        4'hE, 4'h7, 4'h8, 4'h4, 4'h1, 4'h9, 4'h2, 4'hF,
        4'h5, 4'hA, 4'hB, 4'h0, 4'h6, 4'hC, 4'hD, 4'h3
    };

    localparam t_perm PERM = '{
        4'd15, 4'd11, 4'd7, 4'd3, 4'd2, 4'd14, 4'd10, 4'd6,
        4'd5, 4'd1, 4'd13, 4'd9, 4'd8, 4'd4, 4'd0, 4'd12
    };

    function automatic logic [15:0] rol8(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

    function automatic logic [15:0] ror3(input logic [15:0] w);
        return {w[2:0], w[15:3]};
    endfunction

    function automatic logic [15:0] sub16(input logic [15:0] w);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[k*4 +: 4] = SBOX[w[k*4 +: 4]];
        end
        return r;
    endfunction

    function automatic logic [15:0] perm16(input logic [15:0] w);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            r[PERM[k]] = w[k];
        end
        return r;
    endfunction

    function automatic t_block round_fn(input t_block b_in, input logic [31:0] rk);
        logic [15:0] a, b, c, d, x, u;
        t_block      r;
        a = b_in.hi[31:16];
        b = b_in.hi[15:0];
        c = b_in.lo[31:16];
        d = b_in.lo[15:0];
        x = perm16(sub16(ror3(b)) ^ rol8(a) ^ rk[31:16]);
        u = perm16(sub16(rol8(c)) ^ ror3(d) ^ rk[15:0]);
        r.lo = {x, perm16(b)};
        r.hi = {perm16(c), u};
        return r;
    endfunction

    function automatic t_key key_fn(input t_key k_in, input logic [ROUND_W-1:0] rnd);
        t_key r;
        r.kh = {k_in.kh[50:0], k_in.kl[63:51]};
        r.kl = {k_in.kl[50:0], k_in.kh[63:51]};
        r.kl[7:4] = SBOX[r.kl[7:4]];
        r.kl[3:0] = SBOX[r.kl[3:0]];
        r.kl[63:59] = r.kl[63:59] ^ rnd;
        return r;
    endfunction

endpackage

// ===== rtl/nux_round_cell.sv =====
// one round cell: round logic, key step and a registered handshake stage
`timescale 1ns / 1ps

module nux_round_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nux_pkg::ROUND_W-1:0]  i_round,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  nux_pkg::t_block              i_block,
    input  nux_pkg::t_key                i_key,
    output logic                         o_valid,
    input  logic                         i_ready,
    output nux_pkg::t_block              o_block,
    output nux_pkg::t_key                o_key
);
    import nux_pkg::*;

    logic   r_valid;
    t_block r_block;
    t_key   r_key;
    logic   n_valid;
    logic   load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign n_valid = load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_block <= round_fn(i_block, i_key.kl[31:0]);
            r_key   <= key_fn(i_key, i_round);
        end
    end

    assign o_valid = r_valid;
    assign o_block = r_block;
    assign o_key   = r_key;

endmodule

// ===== rtl/nux_block_encrypt_128.sv =====
// top level of the nux 64/128 block cipher: key registers and a chain of round cells
// each item passes through the chain of round cells, a register per cell
// throughput: one item per cycle while i_ready stays high; each round cell takes one item a cycle
// a stalled output holds only the cells that are full; empty cells keep filling
// reset: synchronous, active low; clears all cell valid bits and both key registers to zero
`timescale 1ns / 1ps

module nux_block_encrypt_128 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nux_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nux_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_plain_high,
    input  logic [31:0]                    i_plain_low,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_cipher_high,
    output logic [31:0]                    o_cipher_low
);
    import nux_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;

    logic   c_valid [ROUND_COUNT+1];
    logic   c_ready [ROUND_COUNT+1];
    t_block c_block [ROUND_COUNT+1];
    t_key   c_key   [ROUND_COUNT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign c_valid[0]    = i_valid;
    assign o_ready       = c_ready[0];
    assign c_block[0].hi = i_plain_high;
    assign c_block[0].lo = i_plain_low;
    assign c_key[0].kh   = r_key_high;
    assign c_key[0].kl   = r_key_low;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
        nux_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (ROUND_W'(g)),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_block (c_block[g]),
            .i_key   (c_key[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_block (c_block[g+1]),
            .o_key   (c_key[g+1])
        );
    end

    assign c_ready[ROUND_COUNT] = i_ready;
    assign o_valid              = c_valid[ROUND_COUNT];
    assign o_cipher_high        = c_block[ROUND_COUNT].hi;
    assign o_cipher_low         = c_block[ROUND_COUNT].lo;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for nux_block_encrypt_128: table-driven and random blocks under several keys
`timescale 1ns / 1ps

module tb;
    import nux_pkg::*;

    localparam int LATENCY     = ROUND_COUNT;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 236;
    localparam int LONG_HOLD   = 250;
    localparam int HOLD_AFTER  = 600;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_KEY_LOW + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = '1;

    localparam logic [3:0] S_TAB [16] = '{
        4'hE, 4'h7, 4'h8, 4'h4, 4'h1, 4'h9, 4'h2, 4'hF,
        4'h5, 4'hA, 4'hB, 4'h0, 4'h6, 4'hC, 4'hD, 4'h3
    };
    localparam logic [3:0] P_TAB [16] = '{
        4'd15, 4'd11, 4'd7, 4'd3, 4'd2, 4'd14, 4'd10, 4'd6,
        4'd5, 4'd1, 4'd13, 4'd9, 4'd8, 4'd4, 4'd0, 4'd12
    };

    typedef enum logic {ROW_CFG, ROW_BLOCK} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [63:0]            data;
    } t_row;

    localparam int DIR_N = 26;

    t_row dir_rows [DIR_N] = '{
        '{ROW_BLOCK, '0, 64'h0000000000000000},
        '{ROW_BLOCK, '0, 64'hFFFFFFFFFFFFFFFF},
        '{ROW_BLOCK, '0, 64'h0123456789ABCDEF},
        '{ROW_CFG, REG_KEY_HIGH, 64'hFFFFFFFFFFFFFFFF},
        '{ROW_CFG, REG_KEY_LOW, 64'hFFFFFFFFFFFFFFFF},
        '{ROW_BLOCK, '0, 64'h0000000000000000},
        '{ROW_BLOCK, '0, 64'hFFFFFFFFFFFFFFFF},
        '{ROW_BLOCK, '0, 64'h5555555555555555},
        '{ROW_BLOCK, '0, 64'hAAAAAAAAAAAAAAAA},
        // writes to unused indexes must leave the key alone
        '{ROW_CFG, REG_SPARE, 64'h0F0F0F0F0F0F0F0F},
        '{ROW_CFG, REG_LAST, 64'h3C3C3C3C3C3C3C3C},
        '{ROW_BLOCK, '0, 64'h0000000000000000},
        '{ROW_CFG, REG_KEY_HIGH, 64'h0000000000000000},
        '{ROW_CFG, REG_KEY_LOW, 64'h0000000000000001},
        '{ROW_BLOCK, '0, 64'h8000000000000000},
        '{ROW_BLOCK, '0, 64'h0000000000000001},
        '{ROW_CFG, REG_KEY_HIGH, 64'h8000000000000000},
        '{ROW_CFG, REG_KEY_LOW, 64'h0000000000000000},
        '{ROW_BLOCK, '0, 64'h0000000100000000},
        '{ROW_BLOCK, '0, 64'h0000000080000000},
        '{ROW_CFG, REG_KEY_HIGH, 64'h0123456789ABCDEF},
        '{ROW_CFG, REG_KEY_LOW, 64'hFEDCBA9876543210},
        '{ROW_BLOCK, '0, 64'hFFFFFFFF00000000},
        '{ROW_BLOCK, '0, 64'h00000000FFFFFFFF},
        '{ROW_BLOCK, '0, 64'h8000000180000001},
        '{ROW_BLOCK, '0, 64'hFEDCBA9876543210}
    };

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_valid      = 1'b0;
    logic                   o_ready;
    logic [31:0]            i_plain_high = '0;
    logic [31:0]            i_plain_low  = '0;
    logic                   o_valid;
    logic                   i_ready      = 1'b0;
    logic [31:0]            o_cipher_high;
    logic [31:0]            o_cipher_low;

    logic [63:0]    cur_key_hi = '0;
    logic [63:0]    cur_key_lo = '0;
    logic [63:0]    cipher_q [$];
    logic [63:0]    want_ct;

    int n_errors       = 0;
    int n_blocks       = 0;
    int n_results      = 0;
    int n_cfg_writes   = 0;
    int n_stall_cycles = 0;
    int rx_idle_pct    = 0;
    int rx_hold_left   = 0;
    bit long_hold_done = 1'b0;

    nux_block_encrypt_128 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_plain_high  (i_plain_high),
        .i_plain_low   (i_plain_low),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cipher_high (o_cipher_high),
        .o_cipher_low  (o_cipher_low)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] sub_word(input logic [15:0] w);
        logic [15:0] r;
        for (int k = 0; k < 4; k++) begin
            r[4*k +: 4] = S_TAB[w[4*k +: 4]];
        end
        return r;
    endfunction

    function automatic logic [15:0] perm_word(input logic [15:0] w);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            r[P_TAB[k]] = w[k];
        end
        return r;
    endfunction

    function automatic logic [63:0] encrypt_block(input logic [63:0] pt, input logic [63:0] kh,
                                                  input logic [63:0] kl);
        logic [31:0]    hi;
        logic [31:0]    lo;
        logic [127:0]   k;
        logic [15:0]    a, b, c, d, x, u;
        hi = pt[63:32];
        lo = pt[31:0];
        k  = {kh, kl};
        for (int r = 0; r < ROUND_COUNT; r++) begin
            a = hi[31:16];
            b = hi[15:0];
            c = lo[31:16];
            d = lo[15:0];
            x = perm_word(sub_word({b[2:0], b[15:3]}) ^ {a[7:0], a[15:8]} ^ k[31:16]);
            u = perm_word(sub_word({c[7:0], c[15:8]}) ^ {d[2:0], d[15:3]} ^ k[15:0]);
            lo = {x, perm_word(b)};
            hi = {perm_word(c), u};
            // key schedule: rotate the 128-bit key, substitute the low byte, mix in the round
            k = {k[114:0], k[127:115]};
            k[7:4]   = S_TAB[k[7:4]];
            k[3:0]   = S_TAB[k[3:0]];
            k[63:59] = k[63:59] ^ 5'(r);
        end
        return {hi, lo};
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [63:0] rand_block();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(63);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // leaves the write enable high so back-to-back writes need no second assignment
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        n_cfg_writes++;
        if (idx == REG_KEY_HIGH) begin
            cur_key_hi = val;
        end else if (idx == REG_KEY_LOW) begin
            cur_key_lo = val;
        end
    endtask

    task automatic send_block(input logic [63:0] pt, input int gap);
        logic [63:0] ct;
        ct = encrypt_block(pt, cur_key_hi, cur_key_lo);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_plain_high <= pt[63:32];
        i_plain_low  <= pt[31:0];
        do @(posedge i_clk); while (!o_ready);
        cipher_q.push_back(ct);
        n_blocks++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // result side: checking and ready throttling
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready) begin
                n_stall_cycles++;
            end
            if (o_valid && i_ready) begin
                n_results++;
                if (cipher_q.size() == 0) begin
                    $error("item with no block in flight: %h %h", o_cipher_high, o_cipher_low);
                    n_errors++;
                end else begin
                    want_ct = cipher_q.pop_front();
                    if (o_cipher_high !== want_ct[63:32]) begin
                        $error("cipher_high: expected %h, got %h", want_ct[63:32], o_cipher_high);
                        n_errors++;
                    end
                    if (o_cipher_low !== want_ct[31:0]) begin
                        $error("cipher_low: expected %h, got %h", want_ct[31:0], o_cipher_low);
                        n_errors++;
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
            end else if (!long_hold_done && n_results >= HOLD_AFTER) begin
                // long hold-off so the cell chain fills and the input stalls
                rx_hold_left   = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                rx_hold_left = pick_gap(rx_idle_pct);
            end
            i_ready <= (rx_hold_left == 0);
        end
    end

    initial begin
        int             tx_pct;
        logic [63:0]    kh;
        logic [63:0]    kl;
        bit             busy;
        busy = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rx_idle_pct = 20;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                if (busy) begin
                    wait_idle();
                    busy = 1'b0;
                end
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                if (i_cfg_we) begin
                    i_cfg_we <= 1'b0;
                end
                send_block(dir_rows[i].data, pick_gap(20));
                busy = 1'b1;
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case (ph)
                1: begin kh = '0; kl = '0; end
                2: begin kh = '1; kl = '1; end
                default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
            endcase
            if (ph >= 3 && $urandom_range(2) == 0) begin
                if ($urandom_range(1)) begin
                    cfg_write(REG_KEY_HIGH, kh);
                end else begin
                    cfg_write(REG_KEY_LOW, kl);
                end
            end else begin
                cfg_write(REG_KEY_HIGH, kh);
                cfg_write(REG_KEY_LOW, kl);
            end
            if ($urandom_range(2) == 0) begin
                cfg_write(CFG_IDX_W'($urandom_range(REG_LAST, REG_SPARE)),
                          {$urandom, $urandom});
            end
            i_cfg_we <= 1'b0;
            tx_pct      = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 10 : 35;
            rx_idle_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 10 : 35;
            repeat (PHASE_ITEMS) send_block(rand_block(), pick_gap(tx_pct));
        end
        wait_idle();

        $display("checked %0d blocks (%0d results) over %0d register writes", n_blocks,
                 n_results, n_cfg_writes);
        $display("input held off for %0d cycles by output backpressure", n_stall_cycles);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d blocks still in flight", cipher_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
